[hw/rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, constants and shared types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int EDGE_SHIFT  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int EDGE_W      = COORD_WIDTH - EDGE_SHIFT + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int LEAD_W      = $clog2(CROSS_W);
	localparam int NORM_TOP    = 30;
	localparam int NMAG_W      = NORM_TOP + 1;
	localparam int SHIFT_W     = CROSS_W + NORM_TOP;
	localparam int SQ_W        = 2 * NMAG_W;
	localparam int SUM_W       = 64;
	localparam int ROOT_STEPS  = 32;
	localparam int ROOT_W      = 32;
	localparam int Q_W         = 15;
	localparam int NUM_W       = 48;
	localparam int DEN_W       = ROOT_W + 2;
	localparam int FRAC_SH     = 15;
	localparam int OUT_W       = 16;
	localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(16384);

	typedef struct packed {
		logic                        degen;
		logic [2:0]                  neg;
		logic [2:0][NMAG_W-1:0]      mag;
	} side_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic signed [OUT_W-1:0] nz;
		logic                    degenerate;
	} res_t;

endpackage

[hw/rtl/tfn_in_if.sv]
// ----------------------------------------------------------------------------
// tfn_in_if
// Triangle input channel: three vertex positions per beat.
// ----------------------------------------------------------------------------
interface tfn_in_if;
	logic valid;
	logic ready;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] ax, ay, az;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] bx, by_coord, bz;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] cx, cy, cz;

	modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
	modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

[hw/rtl/tfn_out_if.sv]
// ----------------------------------------------------------------------------
// tfn_out_if
// Normal output channel: one unit normal and degenerate flag per beat.
// ----------------------------------------------------------------------------
interface tfn_out_if;
	logic valid;
	logic ready;
	logic signed [tfn_pkg::OUT_W-1:0] nx, ny, nz;
	logic degenerate;

	modport source (output valid, nx, ny, nz, degenerate, input ready);
	modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

[hw/rtl/tfn_isqrt.sv]
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one result bit per stage, side data carried.
// ----------------------------------------------------------------------------
module tfn_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  tfn_pkg::side_t                side_in,
	input  logic [tfn_pkg::SUM_W-1:0]     sum_in,
	output logic                          valid_out,
	output tfn_pkg::side_t                side_out,
	output logic [tfn_pkg::ROOT_W-1:0]    root_out
);

	localparam int N = tfn_pkg::ROOT_STEPS;
	localparam int W = tfn_pkg::SUM_W;

	logic [W-1:0]   x_s    [1:N];
	logic [W-1:0]   r_s    [1:N];
	tfn_pkg::side_t side_s [1:N];
	logic           vld_s  [1:N];

	logic [W-1:0]   cur_x    [0:N-1];
	logic [W-1:0]   cur_r    [0:N-1];
	tfn_pkg::side_t cur_side [0:N-1];
	logic           cur_vld  [0:N-1];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_step
			localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * i);
			logic [W:0]   trial;
			logic [W-1:0] nx_x;
			logic [W-1:0] nx_r;

			if (i == 0) begin : g_first
				assign cur_x[0]    = sum_in;
				assign cur_r[0]    = '0;
				assign cur_side[0] = side_in;
				assign cur_vld[0]  = valid_in;
			end else begin : g_next
				assign cur_x[i]    = x_s[i];
				assign cur_r[i]    = r_s[i];
				assign cur_side[i] = side_s[i];
				assign cur_vld[i]  = vld_s[i];
			end

			always_comb begin
				trial = {1'b0, cur_r[i]} + {1'b0, BIT};
				if ({1'b0, cur_x[i]} >= trial) begin
					nx_x = cur_x[i] - trial[W-1:0];
					nx_r = (cur_r[i] >> 1) + BIT;
				end else begin
					nx_x = cur_x[i];
					nx_r = cur_r[i] >> 1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i+1] <= 1'b0;
				end else if (en) begin
					vld_s[i+1] <= cur_vld[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i+1]    <= nx_x;
					r_s[i+1]    <= nx_r;
					side_s[i+1] <= cur_side[i];
				end
			end
		end
	endgenerate

	assign valid_out = vld_s[N];
	assign side_out  = side_s[N];
	assign root_out  = r_s[N][tfn_pkg::ROOT_W-1:0];

endmodule

[hw/rtl/tfn_div.sv]
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined rounded divide of the three magnitudes by the root, one quotient
// bit per stage, then cap, sign and output register.
// ----------------------------------------------------------------------------
module tfn_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  tfn_pkg::side_t                side_in,
	input  logic [tfn_pkg::ROOT_W-1:0]    root_in,
	output logic                          valid_out,
	output tfn_pkg::res_t                 res_out
);

	localparam int N  = tfn_pkg::Q_W;
	localparam int NW = tfn_pkg::NUM_W;

	logic [2:0][NW-1:0]           n_s   [1:N];
	logic [NW-1:0]                d_s   [1:N];
	logic [2:0][tfn_pkg::Q_W-1:0] q_s   [1:N];
	logic [2:0]                   neg_s [1:N];
	logic                         dg_s  [1:N];
	logic                         vld_s [1:N];

	logic [2:0][NW-1:0]           cur_n   [0:N-1];
	logic [NW-1:0]                cur_d   [0:N-1];
	logic [2:0][tfn_pkg::Q_W-1:0] cur_q   [0:N-1];
	logic [2:0]                   cur_neg [0:N-1];
	logic                         cur_dg  [0:N-1];
	logic                         cur_vld [0:N-1];

	logic [tfn_pkg::ROOT_W-1:0] r_eff;
	logic [2:0][NW-1:0]         num0;

	always_comb begin
		r_eff = (root_in == '0) ? tfn_pkg::ROOT_W'(1) : root_in;
		for (int c = 0; c < 3; c++) begin
			num0[c] = (NW'(side_in.mag[c]) << tfn_pkg::FRAC_SH) + NW'(r_eff);
		end
	end

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_step
			localparam int BITPOS = N - 1 - i;
			logic [2:0][NW-1:0]           nx_n;
			logic [2:0][tfn_pkg::Q_W-1:0] nx_q;
			logic [NW-1:0]                dsh;

			if (i == 0) begin : g_first
				assign cur_n[0]   = num0;
				assign cur_d[0]   = NW'({r_eff, 1'b0});
				assign cur_q[0]   = '0;
				assign cur_neg[0] = side_in.neg;
				assign cur_dg[0]  = side_in.degen;
				assign cur_vld[0] = valid_in;
			end else begin : g_next
				assign cur_n[i]   = n_s[i];
				assign cur_d[i]   = d_s[i];
				assign cur_q[i]   = q_s[i];
				assign cur_neg[i] = neg_s[i];
				assign cur_dg[i]  = dg_s[i];
				assign cur_vld[i] = vld_s[i];
			end

			always_comb begin
				dsh  = cur_d[i] << BITPOS;
				nx_n = cur_n[i];
				nx_q = cur_q[i];
				for (int c = 0; c < 3; c++) begin
					if (cur_n[i][c] >= dsh) begin
						nx_n[c]         = cur_n[i][c] - dsh;
						nx_q[c][BITPOS] = 1'b1;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i+1] <= 1'b0;
				end else if (en) begin
					vld_s[i+1] <= cur_vld[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					n_s[i+1]   <= nx_n;
					d_s[i+1]   <= cur_d[i];
					q_s[i+1]   <= nx_q;
					neg_s[i+1] <= cur_neg[i];
					dg_s[i+1]  <= cur_dg[i];
				end
			end
		end
	endgenerate

	logic [2:0][tfn_pkg::OUT_W-1:0] comp;

	always_comb begin
		logic [tfn_pkg::Q_W-1:0] qc;
		for (int c = 0; c < 3; c++) begin
			qc      = (q_s[N][c] > tfn_pkg::UNIT_ONE) ? tfn_pkg::UNIT_ONE : q_s[N][c];
			comp[c] = neg_s[N][c] ? -tfn_pkg::OUT_W'(qc) : tfn_pkg::OUT_W'(qc);
		end
	end

	logic          out_v_q;
	tfn_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.nx         <= comp[0];
			res_q.ny         <= comp[1];
			res_q.nz         <= comp[2];
			res_q.degenerate <= dg_s[N];
		end
	end

	assign valid_out = out_v_q;
	assign res_out   = res_q;

endmodule

[hw/rtl/triangle_face_normal_top.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Flat face normal of a triangle: edges, cross product, normalize to Q1.14.
// ----------------------------------------------------------------------------
// Takes one triangle per beat and returns its unit normal after 9 front
// stages (edges, products, cross, magnitude, max, leading one, shift,
// squares, sum), 32 square root stages and 15 divider stages plus the output
// register. One triangle enters every cycle; the whole pipeline holds while
// an output beat waits, so input ready is low only when the output register
// is full and not taken. A zero cross product gives a zero normal with the
// degenerate flag set.
module triangle_face_normal_top (
	input  logic       clk,
	input  logic       arst_n,
	tfn_in_if.sink     in_ch,
	tfn_out_if.source  out_ch
);

	localparam int CW = tfn_pkg::COORD_WIDTH;
	localparam int EW = tfn_pkg::EDGE_W;
	localparam int PW = tfn_pkg::PROD_W;
	localparam int XW = tfn_pkg::CROSS_W;
	localparam int MW = tfn_pkg::NMAG_W;

	logic en;
	logic out_valid;
	tfn_pkg::res_t res;

	assign en          = !out_valid || out_ch.ready;
	assign in_ch.ready = en;

	// edges
	logic signed [CW-1:0] a [3], b [3], c [3];
	logic signed [EW-1:0] e1 [3], e2 [3];

	assign a = '{in_ch.ax, in_ch.ay, in_ch.az};
	assign b = '{in_ch.bx, in_ch.by_coord, in_ch.bz};
	assign c = '{in_ch.cx, in_ch.cy, in_ch.cz};

	always_comb begin
		logic signed [tfn_pkg::DIFF_W-1:0] d1, d2;
		for (int k = 0; k < 3; k++) begin
			d1    = tfn_pkg::DIFF_W'(b[k]) - tfn_pkg::DIFF_W'(a[k]);
			d2    = tfn_pkg::DIFF_W'(c[k]) - tfn_pkg::DIFF_W'(a[k]);
			e1[k] = EW'(d1 >>> tfn_pkg::EDGE_SHIFT);
			e2[k] = EW'(d2 >>> tfn_pkg::EDGE_SHIFT);
		end
	end

	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [XW-1:0] cr_s3 [3];
	logic [XW-1:0]        mag_s4 [3], mag_s5 [3], mag_s6 [3];
	logic [2:0]           neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [XW-1:0]        m_s5;
	logic [tfn_pkg::LEAD_W-1:0] lead_s6;
	logic                 dg_s6, dg_s7, dg_s8, dg_s9;
	logic [2:0][MW-1:0]   nm_s7, nm_s8, nm_s9;
	logic [tfn_pkg::SQ_W-1:0]  sq_s8 [3];
	logic [tfn_pkg::SUM_W-1:0] sum_s9;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{in_ch.valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	logic [XW-1:0]              m_nx;
	logic [tfn_pkg::LEAD_W-1:0] lead_nx;
	logic [2:0][MW-1:0]         nm_nx;

	always_comb begin
		logic [tfn_pkg::SHIFT_W-1:0] ext;
		m_nx = mag_s4[0];
		if (mag_s4[1] > m_nx) m_nx = mag_s4[1];
		if (mag_s4[2] > m_nx) m_nx = mag_s4[2];
		lead_nx = '0;
		for (int k = 0; k < XW; k++) begin
			if (m_s5[k]) lead_nx = tfn_pkg::LEAD_W'(k);
		end
		for (int k = 0; k < 3; k++) begin
			ext = tfn_pkg::SHIFT_W'(mag_s6[k]);
			if (int'(lead_s6) < tfn_pkg::NORM_TOP) begin
				ext = ext << (tfn_pkg::NORM_TOP - int'(lead_s6));
			end else begin
				ext = ext >> (int'(lead_s6) - tfn_pkg::NORM_TOP);
			end
			nm_nx[k] = ext[MW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1 <= e1;
			e2_s1 <= e2;
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int k = 0; k < 3; k++) begin
				cr_s3[k]  <= XW'(p_s2[2*k]) - XW'(p_s2[2*k+1]);
				neg_s4[k] <= cr_s3[k][XW-1];
				mag_s4[k] <= cr_s3[k][XW-1] ? XW'(-cr_s3[k]) : XW'(cr_s3[k]);
			end
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			m_s5    <= m_nx;
			mag_s6  <= mag_s5;
			neg_s6  <= neg_s5;
			lead_s6 <= lead_nx;
			dg_s6   <= (m_s5 == '0);
			nm_s7   <= nm_nx;
			neg_s7  <= neg_s6;
			dg_s7   <= dg_s6;
			for (int k = 0; k < 3; k++) begin
				sq_s8[k] <= nm_s7[k] * nm_s7[k];
			end
			nm_s8  <= nm_s7;
			neg_s8 <= neg_s7;
			dg_s8  <= dg_s7;
			sum_s9 <= tfn_pkg::SUM_W'(sq_s8[0]) + tfn_pkg::SUM_W'(sq_s8[1])
			        + tfn_pkg::SUM_W'(sq_s8[2]);
			nm_s9  <= nm_s8;
			neg_s9 <= neg_s8;
			dg_s9  <= dg_s8;
		end
	end

	tfn_pkg::side_t side_s9;
	tfn_pkg::side_t side_rt;
	logic           v_rt;
	logic [tfn_pkg::ROOT_W-1:0] root_rt;

	assign side_s9.degen = dg_s9;
	assign side_s9.neg   = neg_s9;
	assign side_s9.mag   = nm_s9;

	tfn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s9),
		.side_in   (side_s9),
		.sum_in    (sum_s9),
		.valid_out (v_rt),
		.side_out  (side_rt),
		.root_out  (root_rt)
	);

	tfn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_rt),
		.side_in   (side_rt),
		.root_in   (root_rt),
		.valid_out (out_valid),
		.res_out   (res)
	);

	assign out_ch.valid      = out_valid;
	assign out_ch.nx         = res.nx;
	assign out_ch.ny         = res.ny;
	assign out_ch.nz         = res.nz;
	assign out_ch.degenerate = res.degenerate;

endmodule
